// File: rtl/core/lcdseq_pkg.sv
`timescale 1ns / 1ps

package lcdseq_pkg;

  // Core clock cycles in one microsecond.
  localparam int unsigned CLOCKS_PER_US = 50;
  localparam int unsigned PRESCALE_W    = 8;
  localparam int unsigned TIMER_W       = 13;
  localparam int unsigned CFG_DATA_W    = 13;
  localparam int unsigned CFG_INDEX_W   = 2;

  // Request codes.
  localparam logic [1:0] OP_INIT = 2'd0;
  localparam logic [1:0] OP_CMD  = 2'd1;
  localparam logic [1:0] OP_CHAR = 2'd2;
  localparam logic [1:0] OP_GOTO = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_FOUR_BIT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EN_HIGH   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_POWER_UP  = 2'd3;

  // Reset values of the configuration registers.
  localparam logic        RST_FOUR_BIT = 1'b1;
  localparam logic [7:0]  RST_EN_HIGH  = 8'd10;
  localparam logic [9:0]  RST_SETTLE   = 10'd100;
  localparam logic [12:0] RST_POWER_UP = 13'd5000;

  // Index of the final byte of the init sequence in each bus mode.
  localparam logic [2:0] INIT_LAST_4 = 3'd4;
  localparam logic [2:0] INIT_LAST_8 = 3'd2;

  typedef enum logic [1:0] {
    TMR_POWER,
    TMR_HIGH,
    TMR_GAP
  } tmr_sel_t;

  typedef struct packed {
    logic       capture;
    logic       load_timer;
    tmr_sel_t   timer_sel;
    logic       emit;
    logic [2:0] byte_idx;
    logic       nibble_lo;
    logic       last;
  } lcdseq_cmd_t;

  typedef struct packed {
    logic timer_done;
    logic out_free;
    logic is_init;
    logic four_bit;
  } lcdseq_stat_t;

  // Fixed mode-set sequence sent by an init request.
  function automatic logic [7:0] init_byte(input logic four_bit, input logic [2:0] idx);
    logic [7:0] b;
    b = 8'h01;
    if (four_bit) begin
      case (idx)
        3'd0:    b = 8'h33;
        3'd1:    b = 8'h32;
        3'd2:    b = 8'h28;
        3'd3:    b = 8'h0E;
        default: b = 8'h01;
      endcase
    end else begin
      case (idx)
        3'd0:    b = 8'h38;
        3'd1:    b = 8'h0E;
        default: b = 8'h01;
      endcase
    end
    return b;
  endfunction

endpackage

// File: rtl/core/lcdseq_ctrl.sv
`timescale 1ns / 1ps

module lcdseq_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  lcdseq_pkg::lcdseq_stat_t stat,
  output lcdseq_pkg::lcdseq_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POWER,
    S_LOAD,
    S_HIGH,
    S_GAP
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] byte_idx_r, byte_idx_nxt;
  logic       nibble_r, nibble_nxt;
  logic       last_r, last_nxt;
  logic [2:0] last_idx;
  logic       is_last;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    if (stat.is_init) begin
      last_idx = stat.four_bit ? lcdseq_pkg::INIT_LAST_4 : lcdseq_pkg::INIT_LAST_8;
    end else begin
      last_idx = 3'd0;
    end
    is_last = (byte_idx_r == last_idx) && (!stat.four_bit || nibble_r);
  end

  always_comb begin
    state_nxt      = state_r;
    byte_idx_nxt   = byte_idx_r;
    nibble_nxt     = nibble_r;
    last_nxt       = last_r;
    cmd            = '0;
    cmd.timer_sel  = lcdseq_pkg::TMR_POWER;
    cmd.byte_idx   = byte_idx_r;
    cmd.nibble_lo  = nibble_r;
    cmd.last       = is_last;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture    = 1'b1;
          cmd.load_timer = 1'b1;
          byte_idx_nxt   = 3'd0;
          nibble_nxt     = 1'b0;
          last_nxt       = 1'b0;
          state_nxt      = S_POWER;
        end
      end
      S_POWER: begin
        if (stat.timer_done) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (stat.out_free) begin
          cmd.emit       = 1'b1;
          cmd.load_timer = 1'b1;
          cmd.timer_sel  = lcdseq_pkg::TMR_HIGH;
          last_nxt       = is_last;
          state_nxt      = S_HIGH;
        end
      end
      S_HIGH: begin
        if (stat.timer_done) begin
          cmd.load_timer = 1'b1;
          cmd.timer_sel  = lcdseq_pkg::TMR_GAP;
          state_nxt      = S_GAP;
        end
      end
      S_GAP: begin
        if (stat.timer_done) begin
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            if (stat.four_bit && !nibble_r) begin
              nibble_nxt = 1'b1;
            end else begin
              nibble_nxt   = 1'b0;
              byte_idx_nxt = byte_idx_r + 3'd1;
            end
            state_nxt = S_LOAD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      byte_idx_r <= 3'd0;
      nibble_r   <= 1'b0;
      last_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      byte_idx_r <= byte_idx_nxt;
      nibble_r   <= nibble_nxt;
      last_r     <= last_nxt;
    end
  end

endmodule

// File: rtl/core/lcdseq_dp.sv
`timescale 1ns / 1ps

module lcdseq_dp (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_we,
  input  logic [lcdseq_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [lcdseq_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  input  logic [1:0]                                in_op,
  input  logic [7:0]                                in_byte_value,
  input  logic [5:0]                                in_column,
  input  logic [1:0]                                in_row,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic                                      out_register_select,
  output logic [7:0]                                out_data_lines,
  output logic                                      out_last,
  input  lcdseq_pkg::lcdseq_cmd_t                   cmd,
  output lcdseq_pkg::lcdseq_stat_t                  stat
);

  localparam logic [lcdseq_pkg::PRESCALE_W-1:0] PRESCALE_MAX =
    lcdseq_pkg::PRESCALE_W'(lcdseq_pkg::CLOCKS_PER_US - 1);

  logic        four_bit_r;
  logic [7:0]  en_high_r;
  logic [9:0]  settle_r;
  logic [12:0] power_up_r;

  logic        is_init_r;
  logic [7:0]  req_byte_r;
  logic        req_sel_r;

  logic [lcdseq_pkg::TIMER_W-1:0]    timer_r;
  logic [lcdseq_pkg::PRESCALE_W-1:0] prescale_r;
  logic [lcdseq_pkg::TIMER_W-1:0]    timer_load;

  logic       out_valid_r;
  logic       out_sel_r;
  logic [7:0] out_lines_r;
  logic       out_last_r;

  logic [7:0] req_byte_nxt;
  logic [5:0] col_m1;
  logic [6:0] ddram_addr;
  logic [7:0] cur_byte;
  logic [7:0] cur_lines;

  assign stat.timer_done = (timer_r == '0);
  assign stat.out_free   = !out_valid_r || !out_stall;
  assign stat.is_init    = is_init_r;
  assign stat.four_bit   = four_bit_r;

  assign out_valid           = out_valid_r;
  assign out_register_select = out_sel_r;
  assign out_data_lines      = out_lines_r;
  assign out_last            = out_last_r;

  // Cursor address: row 2 starts at 0x40, every other row at 0x00.
  always_comb begin
    col_m1     = (in_column == 6'd0) ? 6'd0 : in_column - 6'd1;
    ddram_addr = {(in_row == 2'd2), 6'd0} + {1'b0, col_m1};
    case (in_op)
      lcdseq_pkg::OP_GOTO: req_byte_nxt = {1'b1, ddram_addr};
      default:             req_byte_nxt = in_byte_value;
    endcase
  end

  always_comb begin
    case (cmd.timer_sel)
      lcdseq_pkg::TMR_HIGH: timer_load = {5'd0, en_high_r};
      lcdseq_pkg::TMR_GAP:  timer_load = {3'd0, settle_r};
      default: timer_load = (in_op == lcdseq_pkg::OP_INIT) ? power_up_r : '0;
    endcase
  end

  always_comb begin
    cur_byte = is_init_r ? lcdseq_pkg::init_byte(four_bit_r, cmd.byte_idx) : req_byte_r;
    if (!four_bit_r) begin
      cur_lines = cur_byte;
    end else if (cmd.nibble_lo) begin
      cur_lines = {cur_byte[3:0], 4'd0};
    end else begin
      cur_lines = {cur_byte[7:4], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_bit_r <= lcdseq_pkg::RST_FOUR_BIT;
      en_high_r  <= lcdseq_pkg::RST_EN_HIGH;
      settle_r   <= lcdseq_pkg::RST_SETTLE;
      power_up_r <= lcdseq_pkg::RST_POWER_UP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcdseq_pkg::REG_FOUR_BIT: four_bit_r <= cfg_wdata[0];
        lcdseq_pkg::REG_EN_HIGH:  en_high_r  <= cfg_wdata[7:0];
        lcdseq_pkg::REG_SETTLE:   settle_r   <= cfg_wdata[9:0];
        lcdseq_pkg::REG_POWER_UP: power_up_r <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_init_r  <= 1'b0;
      req_byte_r <= 8'd0;
      req_sel_r  <= 1'b0;
    end else if (cmd.capture) begin
      is_init_r  <= (in_op == lcdseq_pkg::OP_INIT);
      req_byte_r <= req_byte_nxt;
      req_sel_r  <= (in_op == lcdseq_pkg::OP_CHAR);
    end
  end

  // Microsecond timer driven by a clock prescaler.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r    <= '0;
      prescale_r <= '0;
    end else if (cmd.load_timer) begin
      timer_r    <= timer_load;
      prescale_r <= '0;
    end else if (timer_r != '0) begin
      if (prescale_r == PRESCALE_MAX) begin
        prescale_r <= '0;
        timer_r    <= timer_r - 1'b1;
      end else begin
        prescale_r <= prescale_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sel_r   <= is_init_r ? 1'b0 : req_sel_r;
      out_lines_r <= cur_lines;
      out_last_r  <= cmd.last;
    end
  end

endmodule

// File: rtl/core/char_lcd_write_sequencer_unit.sv
`timescale 1ns / 1ps
// Character LCD write sequencer for an HD44780-style bus in 4-bit or 8-bit mode.
// The input channel (in_valid / in_stall) takes one request per transaction:
// init, command byte, character byte, or cursor go-to (column, row). The output
// channel (out_valid / out_stall) carries one transaction per bus transfer with
// the register-select level, the data lines and a last flag on the final one.
// Each transfer is paced as an enable pulse of enable_high_us followed by a
// settle gap of settle_gap_us, counted by a prescaled microsecond timer.
// After a request is accepted, the controller steps through its power-up state
// and its load state before the first transfer is registered on the output.
// One request is worked at a time; in_stall stays high until its last settle gap
// ends. A byte in 4-bit mode takes two transfers. Init adds a power_up_us wait
// up front and sends ten transfers (three in 8-bit mode). The timer sets the
// pace; the output register is loaded at the start of each strobe, and if the
// receiver stalls, the next transfer waits until the previous transaction is
// taken, so nothing is lost. Configuration is written through cfg_we /
// cfg_index / cfg_wdata; the user must do so only while idle, which the block
// itself does not enforce. Synchronous reset restores the configuration defaults
// (4-bit mode, 10 us, 100 us, 5000 us) and leaves both channels idle.
module char_lcd_write_sequencer_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [lcdseq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lcdseq_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_op,
  input  logic [7:0]                         in_byte_value,
  input  logic [5:0]                         in_column,
  input  logic [1:0]                         in_row,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_register_select,
  output logic [7:0]                         out_data_lines,
  output logic                               out_last
);

  // Commands from the sequencing controller and status back from the datapath.
  lcdseq_pkg::lcdseq_cmd_t  cmd;
  lcdseq_pkg::lcdseq_stat_t stat;

  lcdseq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the configuration, request byte, timer and output register.
  lcdseq_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_op               (in_op),
    .in_byte_value       (in_byte_value),
    .in_column           (in_column),
    .in_row              (in_row),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_register_select (out_register_select),
    .out_data_lines      (out_data_lines),
    .out_last            (out_last),
    .cmd                 (cmd),
    .stat                (stat)
  );

endmodule

// File: dv/char_lcd_write_sequencer_unit_tb.sv
`timescale 1ns / 1ps

module char_lcd_write_sequencer_unit_tb;
  import lcdseq_pkg::*;

  // Register-select levels on the display bus.
  localparam logic SEL_INSTR = 1'b0;
  localparam logic SEL_DATA  = 1'b1;

  // Display command bytes used by the init sequence and by cursor moves.
  localparam logic [7:0] LCD_WAKE_8BIT_TWICE = 8'h33;
  localparam logic [7:0] LCD_WAKE_THEN_4BIT  = 8'h32;
  localparam logic [7:0] LCD_FUNC_4BIT_2LINE = 8'h28;
  localparam logic [7:0] LCD_FUNC_8BIT_2LINE = 8'h38;
  localparam logic [7:0] LCD_DISPLAY_CURSOR  = 8'h0E;
  localparam logic [7:0] LCD_CLEAR           = 8'h01;
  localparam logic [7:0] LCD_SET_DDRAM       = 8'h80;
  localparam logic [6:0] LCD_LINE2_BASE      = 7'h40;

  // The receiver's long hold-off, used once to back the block up.
  localparam int HOLD_OFF_CYCLES = 3000;
  // Longest correct quiet stretch is a full power-up wait (8191 us) plus one
  // slow strobe (255 + 1023 us).
  localparam int WATCHDOG_LIMIT = 1500000;

  typedef struct packed {
    logic       sel;
    logic [7:0] lines;
    logic       last;
  } lcd_xfer_t;

  // Tracks the bus transfers each accepted request must produce, in order.
  class lcd_bus_scoreboard;
    lcd_xfer_t awaited[$];
    bit        nibble_mode;
    int        mismatches;

    function new();
      nibble_mode = RST_FOUR_BIT;
      mismatches  = 0;
    endfunction

    task report_mismatch(input string what);
      $display("[%0t] bus transfer mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    // A byte goes out whole on an 8-bit bus, or high nibble then low nibble,
    // both placed on the upper four data lines, on a 4-bit bus.
    function void push_byte(input logic sel, input logic [7:0] value);
      lcd_xfer_t t;
      t.sel  = sel;
      t.last = 1'b0;
      if (nibble_mode) begin
        t.lines = {value[7:4], 4'h0};
        awaited.push_back(t);
        t.lines = {value[3:0], 4'h0};
        awaited.push_back(t);
      end else begin
        t.lines = value;
        awaited.push_back(t);
      end
    endfunction

    function void note_request(input logic [1:0] op, input logic [7:0] value,
                               input logic [5:0] column, input logic [1:0] row);
      logic [6:0] addr;
      case (op)
        OP_INIT: begin
          if (nibble_mode) begin
            push_byte(SEL_INSTR, LCD_WAKE_8BIT_TWICE);
            push_byte(SEL_INSTR, LCD_WAKE_THEN_4BIT);
            push_byte(SEL_INSTR, LCD_FUNC_4BIT_2LINE);
          end else begin
            push_byte(SEL_INSTR, LCD_FUNC_8BIT_2LINE);
          end
          push_byte(SEL_INSTR, LCD_DISPLAY_CURSOR);
          push_byte(SEL_INSTR, LCD_CLEAR);
        end
        OP_CMD:  push_byte(SEL_INSTR, value);
        OP_CHAR: push_byte(SEL_DATA, value);
        default: begin
          // Only row 2 selects the second line; a zero column counts as the
          // first one, and large columns are added as they are, still within seven bits.
          addr = (row == 2'd2) ? LCD_LINE2_BASE : 7'h00;
          if (column != 6'd0) addr = addr + 7'(column - 6'd1);
          push_byte(SEL_INSTR, LCD_SET_DDRAM | {1'b0, addr});
        end
      endcase
      awaited[awaited.size() - 1].last = 1'b1;
    endfunction

    task check_transfer(input logic sel, input logic [7:0] lines, input logic last);
      lcd_xfer_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer sel=%0b data=%02h last=%0b",
                                  sel, lines, last));
        return;
      end
      want = awaited.pop_front();
      if (sel !== want.sel)
        report_mismatch($sformatf("register_select %0b, expected %0b", sel, want.sel));
      if (lines !== want.lines)
        report_mismatch($sformatf("data_lines %02h, expected %02h", lines, want.lines));
      if (last !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             in_op;
  logic [7:0]             in_byte_value;
  logic [5:0]             in_column;
  logic [1:0]             in_row;
  logic                   out_valid;
  logic                   out_stall;
  logic                   out_register_select;
  logic [7:0]             out_data_lines;
  logic                   out_last;

  lcd_bus_scoreboard sb;

  // Timing registers as last written; they size the pause before a rewrite.
  int unsigned cur_en_high_us;
  int unsigned cur_settle_us;
  // When set, neither side inserts idle cycles.
  bit          calm;
  // Asks the receiver for one long hold-off.
  bit          hold_off_req;
  int unsigned quiet_cycles;

  char_lcd_write_sequencer_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_byte_value       (in_byte_value),
    .in_column           (in_column),
    .in_row              (in_row),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_register_select (out_register_select),
    .out_data_lines      (out_data_lines),
    .out_last            (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The run is declared hung when neither channel completes a transaction for
  // far longer than the slowest legal strobe or power-up wait could take.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[char_lcd_write_sequencer_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request. The task starts and ends on a falling edge. in_valid
  // is only lowered when an idle gap is drawn, so a back-to-back request never
  // sees valid dropped and raised in the same step.
  task automatic send_request(input logic [1:0] op, input logic [7:0] value,
                              input logic [5:0] column, input logic [1:0] row);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_byte_value <= value;
    in_column     <= column;
    in_row        <= row;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(op, value, column, row);
    @(negedge clk);
  endtask

  // Called on the falling edge right after the final accepted request.
  task automatic stop_requests();
    in_valid <= 1'b0;
  endtask

  // Result side: draws a stall length per transaction, takes the transfer and
  // hands it to the scoreboard. Runs for the whole simulation.
  task automatic take_transfers();
    int w;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        w = HOLD_OFF_CYCLES;
      end else begin
        w = calm ? 0 : $urandom_range(0, 5);
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_transfer(out_register_select, out_data_lines, out_last);
      @(negedge clk);
    end
  endtask

  // Waits for every awaited transfer, then lets the final enable pulse and
  // settle gap run out, since the block stays busy after its last transfer.
  task automatic quiesce();
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat ((cur_en_high_us + cur_settle_us) * CLOCKS_PER_US + 50) @(negedge clk);
  endtask

  // Writes all four registers on consecutive edges while the block is idle.
  task automatic reconfigure(input bit four_bit, input int unsigned en_high_us,
                             input int unsigned settle_us, input int unsigned power_us);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_index <= REG_FOUR_BIT;
    cfg_wdata <= CFG_DATA_W'(four_bit);
    @(negedge clk);
    cfg_index <= REG_EN_HIGH;
    cfg_wdata <= CFG_DATA_W'(en_high_us);
    @(negedge clk);
    cfg_index <= REG_SETTLE;
    cfg_wdata <= CFG_DATA_W'(settle_us);
    @(negedge clk);
    cfg_index <= REG_POWER_UP;
    cfg_wdata <= CFG_DATA_W'(power_us);
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.nibble_mode = four_bit;
    cur_en_high_us = en_high_us;
    cur_settle_us  = settle_us;
  endtask

  // Mostly legal cursor positions, with an occasional out-of-range column or
  // row so that the large-column and fallback cases keep turning up.
  task automatic send_random(input int count);
    logic [1:0] op;
    logic [7:0] value;
    logic [5:0] column;
    logic [1:0] row;
    for (int k = 0; k < count; k++) begin
      calm   = ((k / 10) % 3) == 2;
      op     = 2'($urandom_range(0, 3));
      value  = 8'($urandom);
      column = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(1, 40));
      row    = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3))
                                           : 2'($urandom_range(1, 2));
      send_request(op, value, column, row);
    end
    calm = 1'b0;
  endtask

  initial begin
    sb             = new();
    cur_en_high_us = RST_EN_HIGH;
    cur_settle_us  = RST_SETTLE;
    calm           = 1'b0;
    hold_off_req   = 1'b0;
    quiet_cycles   = 0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_op          = OP_INIT;
    in_byte_value  = '0;
    in_column      = '0;
    in_row         = '0;
    out_stall      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    fork
      take_transfers();
    join_none

    // Reset settings: 4-bit bus at the slow default timing, so keep it short.
    send_request(OP_CMD, LCD_CLEAR, 6'd0, 2'd0);
    send_request(OP_CHAR, 8'h41, 6'd1, 2'd1);
    stop_requests();

    // Fastest timing and no power-up wait on a 4-bit bus. The directed set
    // covers byte extremes, every request kind, and every go-to corner:
    // both lines at both column ends, rows outside 1..2, a zero column,
    // columns past 40, and ignored fields carrying all-ones.
    reconfigure(1'b1, 1, 1, 0);
    send_request(OP_INIT, 8'h00, 6'd0, 2'd0);
    send_request(OP_CMD, 8'h00, 6'd0, 2'd0);
    send_request(OP_CMD, 8'hFF, 6'd63, 2'd3);
    send_request(OP_CHAR, 8'h00, 6'd0, 2'd0);
    send_request(OP_CHAR, 8'hFF, 6'd63, 2'd3);
    send_request(OP_CHAR, 8'hA5, 6'd20, 2'd1);
    send_request(OP_CMD, 8'h5A, 6'd10, 2'd2);
    send_request(OP_GOTO, 8'h00, 6'd1, 2'd1);
    send_request(OP_GOTO, 8'hFF, 6'd40, 2'd2);
    send_request(OP_GOTO, 8'h00, 6'd1, 2'd2);
    send_request(OP_GOTO, 8'h00, 6'd40, 2'd1);
    send_request(OP_GOTO, 8'h00, 6'd5, 2'd0);
    send_request(OP_GOTO, 8'h00, 6'd7, 2'd3);
    send_request(OP_GOTO, 8'h00, 6'd0, 2'd1);
    send_request(OP_GOTO, 8'h00, 6'd0, 2'd2);
    send_request(OP_GOTO, 8'h00, 6'd63, 2'd2);
    send_request(OP_GOTO, 8'h00, 6'd63, 2'd1);
    send_request(OP_GOTO, 8'h00, 6'd41, 2'd3);
    send_request(OP_INIT, 8'hFF, 6'd63, 2'd3);

    // The receiver backs off for a long stretch while requests keep coming.
    hold_off_req = 1'b1;
    send_random(40);
    stop_requests();

    // Slowest strobe and longest power-up setting on an 8-bit bus. Init is
    // left out here, since its power-up wait alone would dominate the run.
    reconfigure(1'b0, 255, 1023, 8191);
    send_request(OP_CMD, 8'hFF, 6'd0, 2'd0);
    send_request(OP_CHAR, 8'h00, 6'd63, 2'd3);
    stop_requests();

    // Fast 8-bit bus with a short power-up wait.
    reconfigure(1'b0, 1, 1, 3);
    send_request(OP_INIT, 8'h00, 6'd0, 2'd0);
    send_request(OP_CHAR, 8'h7E, 6'd0, 2'd0);
    send_request(OP_GOTO, 8'h00, 6'd40, 2'd2);
    send_random(35);
    stop_requests();

    // Back to nibble transfers with moderate timing.
    reconfigure(1'b1, 2, 5, 1);
    send_request(OP_INIT, 8'h00, 6'd0, 2'd0);
    send_random(15);
    stop_requests();

    quiesce();
    if (sb.mismatches == 0) begin
      $display("[char_lcd_write_sequencer_unit] OK");
    end else begin
      $display("[char_lcd_write_sequencer_unit] ERROR");
    end
    $finish;
  end

endmodule
